### src/assert_macros.svh
// assertion macros used by the allocator rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every edge outside reset
`define ASSERT_IMP(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// plain condition checked at every edge
`define ASSERT_ALWAYS(label, clk, cond, msg) \
   label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

### src/ffba_pkg.sv
// shared types and constants of the block allocator
package ffba_pkg;
   localparam int unsigned ADDR_W = 17;
   localparam int unsigned SIZE_W = 17;
   localparam logic [16:0] POOL_LIMIT = 17'd65536;
   localparam logic [0:0]  OP_CLAIM = 1'b0;
   localparam logic [0:0]  OP_FREE  = 1'b1;
   localparam logic [1:0]  REG_POOL_SIZE = 2'd0;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } span_type;
endpackage

### src/ffba_table.sv
// span table memory with one registered read port and one write port
module ffba_table import ffba_pkg::*; #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned IDX_W = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  span_type         wr_data,
   input  logic [IDX_W-1:0] rd_idx,
   output span_type         rd_data
);
   span_type mem [DEPTH];
   span_type rd_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_ff <= mem[rd_idx];
   end

   assign rd_data = rd_ff;
endmodule

### src/first_fit_block_allocator.sv
// first-fit allocator: one item scans and shifts the tables, one entry per step
// a claim scans the free entries and shifts free entries down when one is used up;
// a free searches the allocations, scans the free entries, shifts the allocations
// and merges or inserts the freed span; req_tready low while an item is in work
// synchronous reset and a nonzero pool_size write give one free block at the base
// address, empty allocation table; the base entry is written while reset is held
`include "assert_macros.svh"
module first_fit_block_allocator import ffba_pkg::*; #(
   parameter int unsigned MAX_BLOCKS   = 64,
   parameter int unsigned BASE_ADDRESS = 1000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: operation[0], amount[17:1], block_start[34:18], zero fill
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: ok[0], granted_address[17:1], freed_bytes[34:18], table_full[35]
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
   localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
   localparam logic [ADDR_W-1:0] BASE = ADDR_W'(BASE_ADDRESS);

   typedef enum logic [4:0] {
      S_IDLE, S_CRD, S_CCHK, S_CSH_RD, S_CSH_WR,
      S_FARD, S_FACHK, S_FFRD, S_FFCHK, S_FDEC,
      S_ASH_RD, S_ASH_WR, S_MRG_RD, S_MRG_WR,
      S_SSH_RD, S_SSH_WR, S_INS_RD, S_INS_CHK, S_ISH_RD, S_ISH_WR,
      S_INS_WR, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] free_cnt_ff, free_cnt_in, alloc_cnt_ff, alloc_cnt_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] pred_ff, pred_in, succ_ff, succ_in, found_ff, found_in;
   logic             pred_v_ff, pred_v_in, succ_v_ff, succ_v_in;
   logic [SIZE_W-1:0] amt_ff, amt_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] ssize_ff, ssize_in;
   logic [16:0] pool_ff, pool_in;
   logic        ok_ff, ok_in, full_ff, full_in;
   logic [ADDR_W-1:0] gaddr_ff, gaddr_in;
   logic [SIZE_W-1:0] fbytes_ff, fbytes_in;
   logic        rsp_v_ff, rsp_v_in;

   logic             fw_en, aw_en;
   logic [IDX_W-1:0] fw_idx, fr_idx, aw_idx, ar_idx;
   span_type         fw_data, aw_data, f_rd, a_rd;

   logic        cfg_wr;
   logic [16:0] pool_eff;
   logic [ADDR_W-1:0] f_end;
   logic [ADDR_W-1:0] end_addr;

   ffba_table #(.DEPTH(MAX_BLOCKS), .IDX_W(IDX_W)) u_free (
      .clock(clock), .wr_en(fw_en), .wr_idx(fw_idx), .wr_data(fw_data),
      .rd_idx(fr_idx), .rd_data(f_rd));
   ffba_table #(.DEPTH(MAX_BLOCKS), .IDX_W(IDX_W)) u_alloc (
      .clock(clock), .wr_en(aw_en), .wr_idx(aw_idx), .wr_data(aw_data),
      .rd_idx(ar_idx), .rd_data(a_rd));

   assign csr_pready = 1'b1;
   assign csr_prdata = {15'd0, pool_ff};
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_paddr[2:2] == 1'b0
                   && csr_paddr[1:0] == 2'd0;
   assign pool_eff = (csr_pwdata[16:0] > POOL_LIMIT) ? POOL_LIMIT : csr_pwdata[16:0];
   assign f_end = f_rd.addr + f_rd.size;
   assign end_addr = start_ff + size_ff;
   assign req_tready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = {4'd0, full_ff, fbytes_ff, gaddr_ff, ok_ff};

   // sequencer over the two tables
   always_comb begin
      state_in = state_ff; free_cnt_in = free_cnt_ff; alloc_cnt_in = alloc_cnt_ff;
      i_in = i_ff; pred_in = pred_ff; succ_in = succ_ff; found_in = found_ff;
      pred_v_in = pred_v_ff; succ_v_in = succ_v_ff; amt_in = amt_ff;
      start_in = start_ff; size_in = size_ff; ssize_in = ssize_ff; pool_in = pool_ff;
      ok_in = ok_ff; full_in = full_ff; gaddr_in = gaddr_ff; fbytes_in = fbytes_ff;
      rsp_v_in = rsp_v_ff;
      fw_en = 1'b0; fw_idx = i_ff[IDX_W-1:0]; fw_data = f_rd;
      aw_en = 1'b0; aw_idx = i_ff[IDX_W-1:0]; aw_data = a_rd;
      fr_idx = i_ff[IDX_W-1:0]; ar_idx = i_ff[IDX_W-1:0];
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               amt_in = req_tdata[17:1]; start_in = req_tdata[34:18];
               ok_in = 1'b0; full_in = 1'b0; gaddr_in = '0; fbytes_in = '0;
               i_in = '0; pred_v_in = 1'b0; succ_v_in = 1'b0;
               if (req_tdata[0] == OP_CLAIM) begin
                  state_in = (req_tdata[17:1] == '0 || free_cnt_ff == '0) ? S_OUT : S_CRD;
               end else if (req_tdata[34:18] < BASE || alloc_cnt_ff == '0) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_FARD;
               end
            end
         end
         // claim scan
         S_CRD: state_in = S_CCHK;
         S_CCHK: begin
            if (amt_ff <= f_rd.size) begin
               if (alloc_cnt_ff >= CNT_MAX) begin
                  full_in = 1'b1; state_in = S_OUT;
               end else begin
                  aw_en = 1'b1; aw_idx = alloc_cnt_ff[IDX_W-1:0];
                  aw_data.addr = f_rd.addr; aw_data.size = amt_ff;
                  alloc_cnt_in = alloc_cnt_ff + 1'b1;
                  ok_in = 1'b1; gaddr_in = f_rd.addr;
                  if (amt_ff == f_rd.size) begin
                     free_cnt_in = free_cnt_ff - 1'b1; state_in = S_CSH_RD;
                  end else begin
                     fw_en = 1'b1; fw_data.addr = f_rd.addr + amt_ff;
                     fw_data.size = f_rd.size - amt_ff; state_in = S_OUT;
                  end
               end
            end else if (i_ff + 1'b1 >= free_cnt_ff) begin
               state_in = S_OUT;
            end else begin
               i_in = i_ff + 1'b1; fr_idx = IDX_W'(i_ff + 1'b1); state_in = S_CCHK;
            end
         end
         // shift free entries down over the removed one
         S_CSH_RD: begin
            if (i_ff >= free_cnt_ff) state_in = S_OUT;
            else begin fr_idx = IDX_W'(i_ff + 1'b1); state_in = S_CSH_WR; end
         end
         S_CSH_WR: begin
            fw_en = 1'b1; i_in = i_ff + 1'b1; state_in = S_CSH_RD;
         end
         // free: find allocation
         S_FARD: state_in = S_FACHK;
         S_FACHK: begin
            if (a_rd.addr == start_ff) begin
               found_in = i_ff; size_in = a_rd.size; i_in = '0;
               state_in = (free_cnt_ff == '0) ? S_FDEC : S_FFRD;
            end else if (i_ff + 1'b1 >= alloc_cnt_ff) begin
               state_in = S_OUT;
            end else begin
               i_in = i_ff + 1'b1; ar_idx = IDX_W'(i_ff + 1'b1);
            end
         end
         S_FFRD: state_in = S_FFCHK;
         S_FFCHK: begin
            if (f_end == start_ff) begin pred_in = i_ff; pred_v_in = 1'b1; end
            if (f_rd.addr == end_addr) begin
               succ_in = i_ff; succ_v_in = 1'b1; ssize_in = f_rd.size;
            end
            if (i_ff + 1'b1 >= free_cnt_ff) state_in = S_FDEC;
            else begin i_in = i_ff + 1'b1; fr_idx = IDX_W'(i_ff + 1'b1); end
         end
         S_FDEC: begin
            if (!pred_v_ff && !succ_v_ff && free_cnt_ff >= CNT_MAX) begin
               full_in = 1'b1; state_in = S_OUT;
            end else begin
               ok_in = 1'b1; fbytes_in = size_ff; alloc_cnt_in = alloc_cnt_ff - 1'b1;
               i_in = found_ff; state_in = S_ASH_RD;
            end
         end
         // shift allocations down (count already decremented)
         S_ASH_RD: begin
            if (i_ff >= alloc_cnt_ff) begin
               if (pred_v_ff) begin i_in = pred_ff; state_in = S_MRG_RD; end
               else if (succ_v_ff) begin i_in = succ_ff; state_in = S_MRG_RD; end
               else begin i_in = '0; state_in = S_INS_RD; end
            end else begin ar_idx = IDX_W'(i_ff + 1'b1); state_in = S_ASH_WR; end
         end
         S_ASH_WR: begin aw_en = 1'b1; i_in = i_ff + 1'b1; state_in = S_ASH_RD; end
         S_MRG_RD: state_in = S_MRG_WR;
         S_MRG_WR: begin
            fw_en = 1'b1;
            if (pred_v_ff) begin
               fw_data.size = f_rd.size + size_ff + (succ_v_ff ? ssize_ff : '0);
               if (succ_v_ff) begin
                  free_cnt_in = free_cnt_ff - 1'b1; i_in = succ_ff; state_in = S_SSH_RD;
               end else state_in = S_OUT;
            end else begin
               fw_data.addr = start_ff; fw_data.size = f_rd.size + size_ff;
               state_in = S_OUT;
            end
         end
         S_SSH_RD: begin
            if (i_ff >= free_cnt_ff) state_in = S_OUT;
            else begin fr_idx = IDX_W'(i_ff + 1'b1); state_in = S_SSH_WR; end
         end
         S_SSH_WR: begin fw_en = 1'b1; i_in = i_ff + 1'b1; state_in = S_SSH_RD; end
         // insert in address order
         S_INS_RD: begin
            if (i_ff >= free_cnt_ff) state_in = S_INS_WR;
            else state_in = S_INS_CHK;
         end
         S_INS_CHK: begin
            if (f_rd.addr < start_ff) begin
               i_in = i_ff + 1'b1; fr_idx = IDX_W'(i_ff + 1'b1); state_in = S_INS_RD;
            end else begin
               pred_in = i_ff; i_in = free_cnt_ff; state_in = S_ISH_RD;
            end
         end
         // shift-up step for insertion: move entry i-1 to i
         S_ISH_RD: begin
            if (i_ff == pred_ff) begin
               state_in = S_INS_WR;
            end else begin
               fr_idx = IDX_W'(i_ff - 1'b1); state_in = S_ISH_WR;
            end
         end
         S_ISH_WR: begin
            fw_en = 1'b1; fw_idx = i_ff[IDX_W-1:0]; i_in = i_ff - 1'b1;
            state_in = S_ISH_RD;
         end
         S_INS_WR: begin
            fw_en = 1'b1; fw_data.addr = start_ff; fw_data.size = size_ff;
            free_cnt_in = free_cnt_ff + 1'b1; state_in = S_OUT;
         end
         S_OUT: begin
            rsp_v_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // configuration write reinitialises the tables
      if (cfg_wr) begin
         pool_in = csr_pwdata[16:0]; alloc_cnt_in = '0;
         free_cnt_in = (pool_eff == '0) ? '0 : CNT_W'(1);
         fw_en = 1'b1; fw_idx = '0; fw_data.addr = BASE; fw_data.size = pool_eff;
      end
      // reset writes the base free block covering the whole pool
      if (reset) begin
         fw_en = 1'b1; fw_idx = '0; fw_data.addr = BASE; fw_data.size = POOL_LIMIT;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; free_cnt_ff <= CNT_W'(1); alloc_cnt_ff <= '0;
         pool_ff <= POOL_LIMIT; rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; free_cnt_ff <= free_cnt_in; alloc_cnt_ff <= alloc_cnt_in;
         pool_ff <= pool_in; rsp_v_ff <= rsp_v_in;
      end
      i_ff <= i_in; pred_ff <= pred_in; succ_ff <= succ_in; found_ff <= found_in;
      pred_v_ff <= pred_v_in; succ_v_ff <= succ_v_in; amt_ff <= amt_in;
      start_ff <= start_in; size_ff <= size_in; ssize_ff <= ssize_in;
      ok_ff <= ok_in; full_ff <= full_in; gaddr_ff <= gaddr_in; fbytes_ff <= fbytes_in;
   end

   `ASSERT_IMP(a_cnt_free, clock, reset, free_cnt_ff <= CNT_MAX, "free count overflow")
   `ASSERT_IMP(a_cnt_alloc, clock, reset, alloc_cnt_ff <= CNT_MAX, "alloc count overflow")
   `ASSERT_IMP(a_busy, clock, reset, !(rsp_v_ff && req_tready), "ready while result held")
endmodule
